// ===== hdl/dws_pkg.sv =====
// shared types and codes for the deque with search
`timescale 1ns / 1ps
`default_nettype none

package dws_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] position;
        logic [4:0] occupancy;
    } result_t;

    typedef struct packed {
        logic we;
        logic re;
    } store_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dws_store.sv =====
// ring storage with registered read and the shared equality compare unit
`timescale 1ns / 1ps
`default_nettype none

module dws_store #(
    parameter int DEPTH = dws_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               clk,
    input  wire dws_pkg::store_ctl_t ctl,
    input  wire logic [AW-1:0]      waddr,
    input  wire logic [31:0]        wdata,
    input  wire logic [AW-1:0]      raddr,
    input  wire logic [31:0]        key,
    output logic                    match
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign match = (rdata_reg == key);

endmodule

`default_nettype wire

// ===== hdl/deque_with_search.sv =====
// top level of the bounded deque with linear search
//
// usage: a transaction is offered on cmd with start high; it is taken at a
// rising edge where start is high and busy is low. for push front, push back,
// pop front and pop back the result appears on result with done high in the
// cycle after acceptance, and busy stays low so a new transaction can be
// taken every cycle.
// search scans the occupied entries from the front through one read port
// and one 32-bit comparator, one entry per cycle with the compare in the
// cycle after the read; busy is high for the scan. a search on an empty
// queue finishes like a push or pop.
// each result is marked by done high for exactly one cycle;
// the receiver cannot stall it.
// reset clears the front pointer and the count, so the queue is empty; the
// entry store is not cleared and needs no time after reset.
`timescale 1ns / 1ps
`default_nettype none

module deque_with_search #(
    parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire dws_pkg::cmd_t    cmd,
    output logic                  busy,
    output logic                  done,
    output dws_pkg::result_t      result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic [AW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [31:0]       key_reg, key_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [AW-1:0]     rd_slot_reg, rd_slot_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              done_reg, done_next;
    dws_pkg::result_t  result_reg, result_next;

    dws_pkg::store_ctl_t store_ctl;
    logic [AW-1:0]     waddr;
    logic [31:0]       wdata;
    logic              match;

    logic              full;
    logic              empty;
    logic [AW-1:0]     front_dec;
    logic [AW-1:0]     front_inc;
    logic [AW-1:0]     rd_slot_inc;
    logic [SW-1:0]     back_sum;
    logic [AW-1:0]     back_slot;
    logic [1:0]        status;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec   = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc   = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);
    assign rd_slot_inc = (rd_slot_reg == AW'(DEPTH - 1)) ? '0 : rd_slot_reg + AW'(1);

    // front + count stays below twice the depth, one subtract wraps it
    assign back_sum  = SW'(front_reg) + SW'(count_reg);
    assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        key_next       = key_reg;
        rd_idx_next    = rd_idx_reg;
        rd_slot_next   = rd_slot_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        store_ctl.we   = 1'b0;
        store_ctl.re   = 1'b0;
        waddr          = front_dec;
        wdata          = cmd.value;
        status         = dws_pkg::STATUS_OK;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.operation)
                        dws_pkg::OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status = dws_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                store_ctl.we = 1'b1;
                                waddr        = front_dec;
                                front_next   = front_dec;
                                count_next   = count_reg + CW'(1);
                            end
                        end
                        dws_pkg::OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status = dws_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                store_ctl.we = 1'b1;
                                waddr        = back_slot;
                                count_next   = count_reg + CW'(1);
                            end
                        end
                        dws_pkg::OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status = dws_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dws_pkg::OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status = dws_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dws_pkg::OP_SEARCH:
                        begin
                            if (!empty)
                            begin
                                state_next   = ST_SCAN;
                                key_next     = cmd.value;
                                rd_idx_next  = '0;
                                rd_slot_next = front_reg;
                            end
                        end
                        default:
                        begin
                            status = dws_pkg::STATUS_OK;
                        end
                    endcase

                    if ((cmd.operation != dws_pkg::OP_SEARCH) || empty)
                    begin
                        done_next             = 1'b1;
                        result_next.status    = status;
                        result_next.found     = 1'b0;
                        result_next.position  = '0;
                        result_next.occupancy = 5'(count_next);
                    end
                end
            end
            ST_SCAN:
            begin
                if (cmp_valid_reg && match)
                begin
                    state_next            = ST_IDLE;
                    done_next             = 1'b1;
                    result_next.status    = dws_pkg::STATUS_OK;
                    result_next.found     = 1'b1;
                    result_next.position  = 4'(cmp_idx_reg);
                    result_next.occupancy = 5'(count_reg);
                end
                else if (cmp_valid_reg && (cmp_idx_reg == count_reg - CW'(1)))
                begin
                    state_next            = ST_IDLE;
                    done_next             = 1'b1;
                    result_next.status    = dws_pkg::STATUS_OK;
                    result_next.found     = 1'b0;
                    result_next.position  = '0;
                    result_next.occupancy = 5'(count_reg);
                end
                else if (rd_idx_reg < count_reg)
                begin
                    // read the next entry while the previous one is compared
                    store_ctl.re   = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg;
                    rd_idx_next    = rd_idx_reg + CW'(1);
                    rd_slot_next   = rd_slot_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        rd_idx_reg  <= rd_idx_next;
        rd_slot_reg <= rd_slot_next;
        cmp_idx_reg <= cmp_idx_next;
        result_reg  <= result_next;
    end

    dws_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (store_ctl),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_slot_reg),
        .key   (key_reg),
        .match (match)
    );

    assign busy   = (state_reg == ST_SCAN);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for the bounded deque with linear search
`timescale 1ns / 1ps

module tb;
    import dws_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int RANDOM_CMDS = 500;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    done;
    result_t result;

    deque_with_search #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow copy of the deque contents
    logic signed [31:0] shadow_slots [DEPTH];
    int                 shadow_head;
    int                 shadow_fill;

    cmd_t    cmd_backlog [$];
    result_t reply_fifo [$];

    int   cmds_total;
    int   cmds_taken;
    int   mismatches;
    int   idle_cycles;
    logic taken_q;
    int   burst_left;
    int   gap_left;

    int n_push;
    int n_pop;
    int n_search;
    int n_hit;
    int n_full;
    int n_empty;
    int n_unknown;

    logic signed [31:0] value_pool [8];

    function automatic result_t deque_model_step(cmd_t c);
        result_t r;
        int      i;
        r = '0;
        r.status = STATUS_OK;
        case (c.operation)
            OP_PUSH_FRONT:
            begin
                if (shadow_fill >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_head] = c.value;
                    shadow_fill++;
                end
            end
            OP_PUSH_BACK:
            begin
                if (shadow_fill >= DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    shadow_slots[(shadow_head + shadow_fill) % DEPTH] = c.value;
                    shadow_fill++;
                end
            end
            OP_POP_FRONT:
            begin
                if (shadow_fill == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end
            end
            OP_POP_BACK:
            begin
                if (shadow_fill == 0)
                    r.status = STATUS_EMPTY;
                else
                    shadow_fill--;
            end
            OP_SEARCH:
            begin
                // first match from the front wins
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (!r.found && shadow_slots[(shadow_head + i) % DEPTH] == c.value)
                    begin
                        r.found    = 1'b1;
                        r.position = 4'(i);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = 5'(shadow_fill);
        return r;
    endfunction

    task automatic add_cmd(input logic [2:0] op, input logic signed [31:0] val);
        cmd_t c;
        c.operation = op;
        c.value     = val;
        cmd_backlog.push_back(c);
        cmds_total++;
    endtask

    // mostly a small set of values so searches hit and duplicates occur
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // driver: bursts of back-to-back transactions separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(start && !taken_q))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cmd   <= cmd_backlog.pop_front();
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: predict on acceptance, check on done
    always @(posedge clk)
    begin
        result_t want;
        logic    accepted;
        accepted = rst_n && start && !busy;
        taken_q <= accepted;
        if (rst_n && done)
        begin
            if (reply_fifo.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding: %p", $time, result);
                mismatches++;
            end
            else
            begin
                want = reply_fifo.pop_front();
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, result.status);
                    mismatches++;
                end
                if (result.found !== want.found)
                begin
                    $display("%0t: found expected %0d actual %0d",
                             $time, want.found, result.found);
                    mismatches++;
                end
                if (result.position !== want.position)
                begin
                    $display("%0t: position expected %0d actual %0d",
                             $time, want.position, result.position);
                    mismatches++;
                end
                if (result.occupancy !== want.occupancy)
                begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, want.occupancy, result.occupancy);
                    mismatches++;
                end
            end
        end
        if (accepted)
        begin
            want = deque_model_step(cmd);
            reply_fifo.push_back(want);
            cmds_taken++;
            case (cmd.operation)
                OP_PUSH_FRONT, OP_PUSH_BACK: n_push++;
                OP_POP_FRONT, OP_POP_BACK:   n_pop++;
                OP_SEARCH:                   n_search++;
                default:                     n_unknown++;
            endcase
            if (want.found)
                n_hit++;
            if (want.status == STATUS_FULL)
                n_full++;
            if (want.status == STATUS_EMPTY)
                n_empty++;
        end
        if (accepted || (rst_n && done))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int k;
        int r;
        int mode;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        taken_q     = 1'b0;
        shadow_head = 0;
        shadow_fill = 0;
        burst_left  = $urandom_range(1, 24);
        gap_left    = 0;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        value_pool[4] = 32'sd1;
        for (k = 5; k < 8; k++)
            value_pool[k] = $urandom;

        // directed: empty errors, unknown codes, fill to full, extremes
        add_cmd(OP_POP_FRONT, 32'sd0);
        add_cmd(OP_POP_BACK, -32'sd1);
        add_cmd(OP_SEARCH, 32'sd0);
        add_cmd(3'd5, 32'sh5555_5555);
        add_cmd(3'd7, 32'shaaaa_aaaa);
        add_cmd(OP_PUSH_FRONT, 32'sh8000_0000);
        for (k = 0; k < DEPTH - 2; k++)
            add_cmd(OP_PUSH_BACK, 32'sh1000_0000 + k);
        add_cmd(OP_PUSH_BACK, 32'sh7fff_ffff);
        add_cmd(OP_SEARCH, 32'sh7fff_ffff);
        add_cmd(OP_PUSH_FRONT, 32'sd7);
        add_cmd(OP_PUSH_BACK, 32'sd9);
        add_cmd(OP_SEARCH, 32'sh1234_5678);

        // random: alternate fill-heavy, drain-heavy and balanced stretches
        for (k = 0; k < RANDOM_CMDS; k++)
        begin
            mode = (k / 40) % 3;
            r    = $urandom_range(0, 99);
            if (r < 3)
                add_cmd(3'($urandom_range(5, 7)), $urandom);
            else if (r < 23)
                add_cmd(OP_SEARCH, pick_value());
            else if (r < ((mode == 0) ? 83 : (mode == 1) ? 43 : 63))
                add_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
            else
                add_cmd($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmds_taken < cmds_total)
            @(posedge clk);
        while (reply_fifo.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (reply_fifo.size() > 0)
        begin
            $display("%0t: %0d results never arrived", $time, reply_fifo.size());
            mismatches++;
        end
        $display("covered %0d transactions: %0d push, %0d pop, %0d search (%0d hits), %0d unknown",
                 cmds_taken, n_push, n_pop, n_search, n_hit, n_unknown);
        $display("full rejects %0d, empty rejects %0d, mismatches %0d",
                 n_full, n_empty, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
